// ===== rtl/lru_buffer_with_writeback_assert.svh =====
// ----------------------------------------------------------------------------
// LRU buffer assertion macros
// Immediate-implication and next-cycle-implication checks for the buffer.
// ----------------------------------------------------------------------------
`ifndef LRU_BUFFER_WITH_WRITEBACK_ASSERT_SVH
`define LRU_BUFFER_WITH_WRITEBACK_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define LRUBW_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru buffer check failed");

// The consequent must hold in the cycle after the antecedent.
`define LRUBW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru buffer check failed");

`else

`define LRUBW_ASSERT_NOW(label, clk, rst, ante, cons)
`define LRUBW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/lrubw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU buffer package
// Sizes, types and id conversion helpers shared by the cell row and the top.
// ----------------------------------------------------------------------------
package lrubw_pkg;

   // Number of entries in the row and width of a stored id.
   localparam int ENTRIES   = 8;
   localparam int ID_BITS   = 16;
   // Width of the node id on the ports.
   localparam int NODE_BITS = 16;
   // Width that holds both a port id and a stored id.
   localparam int EXT_BITS  = (ID_BITS > NODE_BITS) ? ID_BITS : NODE_BITS;
   // Occupancy counter holds 0 .. ENTRIES.
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);

   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [NODE_BITS-1:0] node_type;
   typedef logic [OCC_BITS-1:0]  occ_type;

   // Per-cell update command: take the younger neighbor, or take the new word.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

   // Port id to stored id: truncate or zero-extend.
   function automatic id_type to_id(input node_type v);
      logic [EXT_BITS-1:0] x;
      x = EXT_BITS'(v);
      return x[ID_BITS-1:0];
   endfunction

   // Stored id to port id: keep the low bits.
   function automatic node_type to_node(input id_type v);
      logic [EXT_BITS-1:0] x;
      x = EXT_BITS'(v);
      return x[NODE_BITS-1:0];
   endfunction

endpackage

// ===== rtl/lrubw_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU buffer cell
// Holds one id and its dirty flag, compares the id against the incoming
// word, and loads either its younger neighbor or the incoming word.
// ----------------------------------------------------------------------------
module lrubw_cell (
   input  logic                      clock,
   input  lrubw_pkg::cell_ctrl_type  ctrl,
   input  lrubw_pkg::id_type         nbr_id,
   input  logic                      nbr_dirty,
   input  lrubw_pkg::id_type         new_id,
   input  logic                      new_dirty,
   output lrubw_pkg::id_type         id,
   output logic                      dirty,
   output logic                      match
);
   import lrubw_pkg::*;

   id_type id_ff, id_in;
   logic   dirty_ff, dirty_in;

   // Next contents: the new word wins, a shift takes the neighbor.
   always_comb begin
      id_in    = id_ff;
      dirty_in = dirty_ff;
      if (ctrl.load) begin
         id_in    = new_id;
         dirty_in = new_dirty;
      end else if (ctrl.shift) begin
         id_in    = nbr_id;
         dirty_in = nbr_dirty;
      end
   end

   // Payload storage needs no reset; the top only reads occupied cells.
   always_ff @(posedge clock) begin
      id_ff    <= id_in;
      dirty_ff <= dirty_in;
   end

   // Lookup compare against the incoming id.
   assign match = (id_ff == new_id);
   assign id    = id_ff;
   assign dirty = dirty_ff;

endmodule

// ===== rtl/lru_buffer_with_writeback.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU buffer with write-back
// Keeps up to ENTRIES node ids ordered oldest (cell 0) to newest, each with
// a dirty flag, and reports the evicted oldest entry on a miss when full.
//
//   channel   ports                                   handshake
//   request   req_node_id, req_modified               start && !busy
//   response  rsp_hit, rsp_evicted_valid,             rsp_valid, one cycle,
//             rsp_evicted_id, rsp_write_back          cannot be held off
//
// One request word is taken every cycle; busy stays low.
// The response appears in the cycle after the request is taken.
// Lookup, reorder and append happen in the same cycle across the cell row:
// every cell compares in parallel and shifts from its younger neighbor.
// Synchronous reset clears rsp_valid and empties the row by clearing only the occupancy count.
// ----------------------------------------------------------------------------
`include "lru_buffer_with_writeback_assert.svh"

module lru_buffer_with_writeback (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  lrubw_pkg::node_type   req_node_id,
   input  logic                  req_modified,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic                  rsp_evicted_valid,
   output lrubw_pkg::node_type   rsp_evicted_id,
   output logic                  rsp_write_back
);
   import lrubw_pkg::*;

   id_type         new_id;
   logic           accept;
   occ_type        occ_ff, occ_in;
   logic           full;
   logic           hit;
   logic           hit_newest;
   logic           evict;

   id_type         cell_id    [ENTRIES];
   logic           cell_dirty [ENTRIES];
   id_type         nbr_id     [ENTRIES];
   logic           nbr_dirty  [ENTRIES];
   cell_ctrl_type  ctrl       [ENTRIES];
   logic [ENTRIES-1:0] match_raw;
   logic [ENTRIES-1:0] occupied;
   logic [ENTRIES-1:0] is_newest;
   logic [ENTRIES-1:0] is_free_slot;
   logic [ENTRIES-1:0] hit_vec;
   logic [ENTRIES-1:0] at_or_above;

   logic           rsp_valid_ff, rsp_valid_in;
   logic           rsp_hit_ff, rsp_hit_in;
   logic           rsp_ev_valid_ff, rsp_ev_valid_in;
   node_type       rsp_ev_id_ff, rsp_ev_id_in;
   logic           rsp_wb_ff, rsp_wb_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign new_id = to_id(req_node_id);

   // Row of cells, each fed by its younger neighbor.
   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      if (g == ENTRIES - 1) begin : g_last
         assign nbr_id[g]    = '0;
         assign nbr_dirty[g] = 1'b0;
      end else begin : g_mid
         assign nbr_id[g]    = cell_id[g+1];
         assign nbr_dirty[g] = cell_dirty[g+1];
      end

      lrubw_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl[g]),
         .nbr_id    (nbr_id[g]),
         .nbr_dirty (nbr_dirty[g]),
         .new_id    (new_id),
         .new_dirty (req_modified),
         .id        (cell_id[g]),
         .dirty     (cell_dirty[g]),
         .match     (match_raw[g])
      );
   end

   // Slot position flags derived from the occupancy count.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         occupied[i]     = (OCC_BITS'(i) < occ_ff);
         is_newest[i]    = (OCC_BITS'(i + 1) == occ_ff);
         is_free_slot[i] = (OCC_BITS'(i) == occ_ff);
      end
   end

   // Lookup: at most one occupied cell can match, ids are kept unique.
   assign hit_vec    = match_raw & occupied;
   assign hit        = |hit_vec;
   assign hit_newest = |(hit_vec & is_newest);
   assign full       = (occ_ff == OCC_BITS'(ENTRIES));
   assign evict      = !hit && full;

   // Cells at or above the hit position close the gap.
   always_comb begin
      at_or_above[0] = hit_vec[0];
      for (int i = 1; i < ENTRIES; i++) begin
         at_or_above[i] = at_or_above[i-1] | hit_vec[i];
      end
   end

   // Per-cell commands for the three update cases.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         ctrl[i].shift = 1'b0;
         ctrl[i].load  = 1'b0;
         if (accept) begin
            if (hit) begin
               if (!hit_newest) begin
                  ctrl[i].shift = at_or_above[i] && occupied[i] && !is_newest[i];
                  ctrl[i].load  = is_newest[i];
               end
            end else if (full) begin
               ctrl[i].shift = (i != ENTRIES - 1);
               ctrl[i].load  = (i == ENTRIES - 1);
            end else begin
               ctrl[i].load  = is_free_slot[i];
            end
         end
      end
   end

   // Occupancy grows only on a miss with free space.
   always_comb begin
      occ_in = occ_ff;
      if (accept && !hit && !full) begin
         occ_in = occ_ff + OCC_BITS'(1);
      end
   end

   // Response word, registered.
   always_comb begin
      rsp_valid_in    = accept;
      rsp_hit_in      = hit;
      rsp_ev_valid_in = evict;
      rsp_ev_id_in    = evict ? to_node(cell_id[0]) : '0;
      rsp_wb_in       = evict && cell_dirty[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff      <= rsp_hit_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_id_ff    <= rsp_ev_id_in;
      rsp_wb_ff       <= rsp_wb_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_id    = rsp_ev_id_ff;
   assign rsp_write_back    = rsp_wb_ff;

   // Checks on the cell row and response timing.
   `LRUBW_ASSERT_NOW(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_BITS'(ENTRIES))
   `LRUBW_ASSERT_NOW(a_single_hit, clock, reset, 1'b1, $onehot0(hit_vec))
   `LRUBW_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, rsp_valid)
   `LRUBW_ASSERT_NEXT(a_evict_full, clock, reset, accept && !full, !rsp_evicted_valid)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU buffer with write-back testbench
// Drives access words into the buffer with random idle gaps and checks every
// response word against a behavioral LRU list kept in the bench. A directed
// opening covers fill, hits on the newest, a middle and the oldest entry, and
// evictions; the random part draws most ids from small rotating pools so hits,
// reorders and dirty evictions happen often.
// ----------------------------------------------------------------------------
module testbench;
   import lrubw_pkg::*;

   // Cycles without any accepted word or response word before the run is abandoned.
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_WORDS = 1500;

   typedef struct {
      node_type node;
      logic     modified;
      int       gap_after;
   } access_type;

   typedef struct packed {
      logic     hit;
      logic     ev_valid;
      node_type ev_id;
      logic     wb;
   } outcome_type;

   logic     clock;
   logic     reset;
   logic     start;
   logic     busy;
   node_type req_node_id;
   logic     req_modified;
   logic     rsp_valid;
   logic     rsp_hit;
   logic     rsp_evicted_valid;
   node_type rsp_evicted_id;
   logic     rsp_write_back;

   access_type  access_queue[$];
   outcome_type predicted_outcomes[$];
   int       words_total;
   int       words_taken;
   int       error_count;
   int       stall_cycles;
   int       idle_left;
   logic     req_taken;

   // Bench copy of the LRU list, oldest at index 0.
   id_type   held_id[ENTRIES];
   logic     held_dirty[ENTRIES];
   int       held_count;

   lru_buffer_with_writeback u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_node_id       (req_node_id),
      .req_modified      (req_modified),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_id    (rsp_evicted_id),
      .rsp_write_back    (rsp_write_back)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Applies one access to the bench list and returns the outcome it causes.
   function automatic outcome_type lru_access(input node_type node, input logic mod);
      logic [63:0] wide;
      id_type      key;
      int          pos;
      outcome_type res;
      wide = 64'(node);
      key = wide[ID_BITS-1:0];
      res = '0;
      pos = -1;
      for (int i = 0; i < held_count; i++) begin
         if (pos < 0 && held_id[i] == key) pos = i;
      end
      if (pos >= 0) begin
         res.hit = 1'b1;
         // A hit on the newest entry leaves the list and its flag alone.
         if (pos != held_count - 1) begin
            for (int i = pos; i < held_count - 1; i++) begin
               held_id[i] = held_id[i + 1];
               held_dirty[i] = held_dirty[i + 1];
            end
            held_id[held_count - 1] = key;
            held_dirty[held_count - 1] = mod;
         end
      end else begin
         // A miss on a full list evicts the oldest entry first.
         if (held_count == ENTRIES) begin
            res.ev_valid = 1'b1;
            wide = 64'(held_id[0]);
            res.ev_id = wide[NODE_BITS-1:0];
            res.wb = held_dirty[0];
            for (int i = 0; i < held_count - 1; i++) begin
               held_id[i] = held_id[i + 1];
               held_dirty[i] = held_dirty[i + 1];
            end
            held_count--;
         end
         held_id[held_count] = key;
         held_dirty[held_count] = mod;
         held_count++;
      end
      return res;
   endfunction

   // Mostly no gap, sometimes a short one, rarely a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   task automatic queue_access(input node_type node, input logic mod, input int gap);
      access_type a;
      a.node = node;
      a.modified = mod;
      a.gap_after = gap;
      access_queue.push_back(a);
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      error_count++;
   endtask

   // Driver: presents the next word at the falling edge once the last one is taken.
   always @(negedge clock) begin
      access_type a;
      if (!reset && (!start || req_taken)) begin
         if (idle_left > 0) begin
            idle_left <= idle_left - 1;
            start <= 1'b0;
         end else if (access_queue.size() > 0) begin
            a = access_queue.pop_front();
            start <= 1'b1;
            req_node_id <= a.node;
            req_modified <= a.modified;
            idle_left <= a.gap_after;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: predicts accepted words and checks response words at the rising edge.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (start && !busy) begin
            predicted_outcomes.push_back(lru_access(req_node_id, req_modified));
            words_taken++;
         end
         if (rsp_valid) begin
            if (predicted_outcomes.size() == 0) begin
               $display("[%0t] response word with no access pending", $time);
               error_count++;
            end else begin
               want = predicted_outcomes.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", longint'(rsp_hit), longint'(want.hit));
               if (rsp_evicted_valid !== want.ev_valid)
                  report_mismatch("evicted_valid", longint'(rsp_evicted_valid),
                                  longint'(want.ev_valid));
               if (rsp_evicted_id !== want.ev_id)
                  report_mismatch("evicted_id", longint'(rsp_evicted_id),
                                  longint'(want.ev_id));
               if (rsp_write_back !== want.wb)
                  report_mismatch("write_back", longint'(rsp_write_back),
                                  longint'(want.wb));
            end
         end
         // Watchdog on cycles where no word moves on either side.
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      node_type pool[$];
      node_type pick;
      int       drain;
      int       burst_left;
      int       gap;
      reset = 1'b1;
      start = 1'b0;
      req_node_id = '0;
      req_modified = 1'b0;
      idle_left = 0;
      stall_cycles = 0;
      words_taken = 0;
      error_count = 0;
      held_count = 0;
      for (int i = 0; i < ENTRIES; i++) begin
         held_id[i] = '0;
         held_dirty[i] = 1'b0;
      end

      // Fill the list with the extreme ids first, then distinct small ones.
      for (int i = 0; i < ENTRIES; i++) begin
         case (i)
            0: pick = 16'h0000;
            1: pick = 16'hFFFF;
            2: pick = 16'h5555;
            3: pick = 16'hAAAA;
            default: pick = node_type'(16'h0100 + i);
         endcase
         queue_access(pick, i[0], pick_gap());
      end
      // Hit on the newest entry, with a differing flag that must be ignored.
      queue_access(node_type'(16'h0100 + ENTRIES - 1), 1'b0, 0);
      // Hit in the middle and on the oldest, each moving to newest.
      queue_access(16'hAAAA, 1'b1, 0);
      queue_access(16'h0000, 1'b0, 1);
      queue_access(16'h0000, 1'b1, 0);
      // Misses on a full list evicting clean and dirty oldest entries, then a hit that reorders.
      queue_access(16'h1234, 1'b1, 0);
      queue_access(16'h8001, 1'b0, 0);
      queue_access(16'h7FFE, 1'b1, 2);
      queue_access(16'hFFFF, 1'b0, 0);
      queue_access(16'hAAAA, 1'b0, 0);

      // Random part: ids mostly from a small rotating pool so hits are frequent.
      burst_left = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            pool.delete();
            for (int k = 0; k < ENTRIES + $urandom_range(0, 6); k++)
               pool.push_back(node_type'($urandom));
         end
         if ($urandom_range(0, 99) < 85)
            pick = pool[$urandom_range(0, pool.size() - 1)];
         else
            pick = node_type'($urandom);
         // Stretches of back-to-back words between the gapped ones.
         if (burst_left > 0) begin
            burst_left--;
            gap = 0;
         end else if ($urandom_range(0, 99) < 3) begin
            burst_left = $urandom_range(20, 80);
            gap = 0;
         end else begin
            gap = pick_gap();
         end
         queue_access(pick, 1'($urandom_range(0, 1)), gap);
      end
      words_total = access_queue.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for every word to be taken and answered, then a short drain.
      wait (words_taken == words_total);
      drain = 0;
      while (predicted_outcomes.size() > 0 && drain < 200) begin
         @(posedge clock);
         drain++;
      end
      repeat (5) @(posedge clock);
      while (predicted_outcomes.size() > 0) begin
         void'(predicted_outcomes.pop_front());
         $display("access left without a response word");
         error_count++;
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== lru_buffer_with_writeback.f =====
+incdir+rtl
rtl/lrubw_pkg.sv
rtl/lrubw_cell.sv
rtl/lru_buffer_with_writeback.sv
bench/testbench.sv
